/* design/q2e_pkg.sv */
// shared types, widths, constants and the arctangent table for the quaternion to euler block
`default_nettype none
package q2e_pkg;

	// input components and products
	localparam int COMP_W = 16;
	localparam int PROD_W = 32;
	// atan2 operand width as it leaves the front end
	localparam int OP_W = 35;
	// clamped asin argument and its cosine
	localparam int P_W = 31;
	localparam int C_W = 30;
	// square root radicand and partial root
	localparam int RAD_W = 59;
	localparam int RES_W = 60;
	localparam int SQ_STEPS = 30;
	// vectoring datapath, normalization magnitude and angle accumulator
	localparam int CW = 44;
	localparam int MAG_W = 41;
	localparam int NORM_STEPS = 6;
	localparam int NORM_TOP = 40;
	localparam int ZW = 35;
	// scaling
	localparam int UW = 37;
	localparam int U_CLAMP_W = 33;
	localparam int SPROD_W = 48;
	localparam int OUT_W = 16;
	localparam int OFS_W = 15;
	localparam int SCALE_FULL = 23040;
	localparam int TABLE_LEN = 24;
	localparam int ANGLE_ITERATIONS_DEF = 16;

	// configuration register indexes
	localparam int CFG_IDX_W = 2;
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ROLL_OFFSET  = 2'd0,
		CFG_PITCH_OFFSET = 2'd1,
		CFG_YAW_OFFSET   = 2'd2
	} cfg_reg_t;

	// operands handed from the front end through the root stages
	typedef struct packed {
		logic signed [OP_W-1:0] rn;
		logic signed [OP_W-1:0] rd;
		logic signed [OP_W-1:0] yn;
		logic signed [OP_W-1:0] yd;
		logic signed [P_W-1:0]  p;
	} front_data_t;

	// one result item
	typedef struct packed {
		logic signed [OUT_W-1:0] roll;
		logic signed [OUT_W-1:0] pitch;
		logic signed [OUT_W-1:0] yaw;
	} euler_t;

	// arctangent of 2^-i in binary turn units (2^32 per turn)
	function automatic logic [29:0] atan_turn(input int i);
		logic [29:0] r;
		case (i)
			0:  r = 30'd536870912;
			1:  r = 30'd316933406;
			2:  r = 30'd167458907;
			3:  r = 30'd85004756;
			4:  r = 30'd42667331;
			5:  r = 30'd21354465;
			6:  r = 30'd10679838;
			7:  r = 30'd5340245;
			8:  r = 30'd2670163;
			9:  r = 30'd1335087;
			10: r = 30'd667544;
			11: r = 30'd333772;
			12: r = 30'd166886;
			13: r = 30'd83443;
			14: r = 30'd41722;
			15: r = 30'd20861;
			16: r = 30'd10430;
			17: r = 30'd5215;
			18: r = 30'd2608;
			19: r = 30'd1304;
			20: r = 30'd652;
			21: r = 30'd326;
			22: r = 30'd163;
			23: r = 30'd81;
			default: r = 30'd0;
		endcase
		return r;
	endfunction

	// magnitude of a vectoring operand, widened to the datapath
	function automatic logic [CW-1:0] mag_of(input logic signed [CW-1:0] v);
		logic [CW-1:0] r;
		r = v[CW-1] ? CW'(-v) : CW'(v);
		return r;
	endfunction

endpackage
`default_nettype wire

/* design/q2e_if.sv */
// valid/ready channels for quaternion items and euler result items
`default_nettype none
interface q2e_quat_if;
	logic valid;
	logic ready;
	logic signed [q2e_pkg::COMP_W-1:0] quat_w;
	logic signed [q2e_pkg::COMP_W-1:0] quat_x;
	logic signed [q2e_pkg::COMP_W-1:0] quat_y;
	logic signed [q2e_pkg::COMP_W-1:0] quat_z;
	modport source (output valid, output quat_w, output quat_x, output quat_y,
		output quat_z, input ready);
	modport sink (input valid, input quat_w, input quat_x, input quat_y,
		input quat_z, output ready);
endinterface

interface q2e_euler_if;
	logic valid;
	logic ready;
	logic signed [q2e_pkg::OUT_W-1:0] roll_scaled;
	logic signed [q2e_pkg::OUT_W-1:0] pitch_scaled;
	logic signed [q2e_pkg::OUT_W-1:0] yaw_scaled;
	modport source (output valid, output roll_scaled, output pitch_scaled,
		output yaw_scaled, input ready);
	modport sink (input valid, input roll_scaled, input pitch_scaled,
		input yaw_scaled, output ready);
endinterface
`default_nettype wire

/* design/q2e_front.sv */
// front end: component products, atan2 operands, clamped asin argument and root radicand
`default_nettype none
module q2e_front (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic en,
	input  wire logic valid_in,
	input  wire logic signed [q2e_pkg::COMP_W-1:0] qw,
	input  wire logic signed [q2e_pkg::COMP_W-1:0] qx,
	input  wire logic signed [q2e_pkg::COMP_W-1:0] qy,
	input  wire logic signed [q2e_pkg::COMP_W-1:0] qz,
	output logic valid_out,
	output q2e_pkg::front_data_t data_out,
	output logic [q2e_pkg::RAD_W-1:0] rad_out
);
	localparam int OP_W = q2e_pkg::OP_W;
	localparam int PW = q2e_pkg::P_W;
	localparam int RW = q2e_pkg::RAD_W;
	localparam logic signed [OP_W-1:0] ONE_Q30 = OP_W'(64'sd1 <<< 30);
	localparam logic signed [PW+1:0] P_LIM = (PW+2)'(64'sd1 <<< 29);
	localparam logic [RW-1:0] RAD_ONE = {1'b1, {(RW-1){1'b0}}};

	logic signed [q2e_pkg::PROD_W-1:0] wx_s1, yz_s1, xx_s1, yy_s1, wz_s1, xy_s1, zz_s1;
	logic signed [q2e_pkg::PROD_W-1:0] wy_s1, zx_s1;
	logic v_s1, v_s2, v_s3, v_s4;
	q2e_pkg::front_data_t d_s2, d_s3, d_s4;
	logic signed [PW+1:0] p_c;
	logic signed [PW-1:0] pc_c;
	logic signed [2*PW-1:0] pp_c;
	logic [RW-1:0] pp_s3, rad_s4;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= valid_in;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// asin argument wy - zx, clamped to plus or minus 2^29
	always_comb begin
		p_c = (PW+2)'(wy_s1) - (PW+2)'(zx_s1);
		if (p_c > P_LIM)
			p_c = P_LIM;
		else if (p_c < -P_LIM)
			p_c = -P_LIM;
		pc_c = PW'(p_c);
	end

	// square of the clamped argument
	assign pp_c = d_s2.p * d_s2.p;

	// products, operand sums, square of p, radicand
	always_ff @(posedge clk) begin
		if (en) begin
			wx_s1 <= qw * qx;
			yz_s1 <= qy * qz;
			xx_s1 <= qx * qx;
			yy_s1 <= qy * qy;
			wz_s1 <= qw * qz;
			xy_s1 <= qx * qy;
			zz_s1 <= qz * qz;
			wy_s1 <= qw * qy;
			zx_s1 <= qz * qx;

			d_s2.rn <= (OP_W'(wx_s1) + OP_W'(yz_s1)) <<< 1;
			d_s2.rd <= ONE_Q30 - ((OP_W'(xx_s1) + OP_W'(yy_s1)) <<< 1);
			d_s2.yn <= (OP_W'(wz_s1) + OP_W'(xy_s1)) <<< 1;
			d_s2.yd <= ONE_Q30 - ((OP_W'(yy_s1) + OP_W'(zz_s1)) <<< 1);
			d_s2.p  <= pc_c;

			d_s3  <= d_s2;
			pp_s3 <= pp_c[RW-1:0];

			d_s4   <= d_s3;
			rad_s4 <= RAD_ONE - pp_s3;
		end
	end

	assign valid_out = v_s4;
	assign data_out = d_s4;
	assign rad_out = rad_s4;
endmodule
`default_nettype wire

/* design/q2e_sqrt.sv */
// pipelined integer square root, one result bit per stage, operands carried alongside
`default_nettype none
module q2e_sqrt (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic en,
	input  wire logic valid_in,
	input  wire q2e_pkg::front_data_t data_in,
	input  wire logic [q2e_pkg::RAD_W-1:0] rad,
	output logic valid_out,
	output q2e_pkg::front_data_t data_out,
	output logic [q2e_pkg::C_W-1:0] root
);
	localparam int N = q2e_pkg::SQ_STEPS;
	localparam int RW = q2e_pkg::RAD_W;
	localparam int SW = q2e_pkg::RES_W;

	logic [RW-1:0] v_s [N];
	logic [SW-1:0] r_s [N];
	q2e_pkg::front_data_t d_s [N];
	logic val_s [N];

	for (genvar k = 0; k < N; k++) begin : g_step
		localparam logic [SW-1:0] BIT = SW'(1) << (RW - 1 - 2 * k);
		logic [RW-1:0] v_i;
		logic [SW-1:0] r_i;
		q2e_pkg::front_data_t d_i;
		logic val_i;
		logic [SW-1:0] trial;
		logic take;

		if (k == 0) begin : g_first
			assign v_i = rad;
			assign r_i = '0;
			assign d_i = data_in;
			assign val_i = valid_in;
		end else begin : g_next
			assign v_i = v_s[k-1];
			assign r_i = r_s[k-1];
			assign d_i = d_s[k-1];
			assign val_i = val_s[k-1];
		end

		// subtract the trial value when it fits
		assign trial = r_i + BIT;
		assign take = {1'b0, v_i} >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				val_s[k] <= 1'b0;
			else if (en)
				val_s[k] <= val_i;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				v_s[k] <= take ? v_i - trial[RW-1:0] : v_i;
				r_s[k] <= take ? (r_i >> 1) + BIT : r_i >> 1;
				d_s[k] <= d_i;
			end
		end
	end

	assign valid_out = val_s[N-1];
	assign data_out = d_s[N-1];
	assign root = r_s[N-1][q2e_pkg::C_W-1:0];
endmodule
`default_nettype wire

/* design/q2e_atan.sv */
// pipelined atan2: operand normalization, quadrant fold and vectoring cordic stages
`default_nettype none
module q2e_atan #(
	parameter int ITER = q2e_pkg::ANGLE_ITERATIONS_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic en,
	input  wire logic valid_in,
	input  wire logic signed [q2e_pkg::OP_W-1:0] y_in,
	input  wire logic signed [q2e_pkg::OP_W-1:0] x_in,
	output logic valid_out,
	output logic signed [q2e_pkg::ZW-1:0] angle
);
	localparam int CW = q2e_pkg::CW;
	localparam int MW = q2e_pkg::MAG_W;
	localparam int ZW = q2e_pkg::ZW;
	localparam int NS = q2e_pkg::NORM_STEPS;
	localparam int NT = q2e_pkg::NORM_TOP;
	localparam logic signed [ZW-1:0] QUARTER = ZW'(64'sd1 <<< 30);

	// magnitude stage
	logic signed [CW-1:0] x_s1, y_s1;
	logic [MW-1:0] m_s1;
	logic zero_s1, v_s1;
	logic signed [CW-1:0] xe_c, ye_c;
	logic [CW-1:0] mor_c;

	assign xe_c = CW'(x_in);
	assign ye_c = CW'(y_in);
	assign mor_c = q2e_pkg::mag_of(xe_c) | q2e_pkg::mag_of(ye_c);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (en)
			v_s1 <= valid_in;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1 <= xe_c;
			y_s1 <= ye_c;
			m_s1 <= mor_c[MW-1:0];
			zero_s1 <= (x_in == '0) && (y_in == '0);
		end
	end

	// normalization: shift by 32, 16, ... 1 while the magnitude stays below 2^40
	logic signed [CW-1:0] nx_s [NS];
	logic signed [CW-1:0] ny_s [NS];
	logic [MW-1:0] nm_s [NS];
	logic nz_s [NS];
	logic nv_s [NS];

	for (genvar j = 0; j < NS; j++) begin : g_norm
		localparam int SH = 32 >> j;
		logic signed [CW-1:0] x_i, y_i;
		logic [MW-1:0] m_i;
		logic z_i, v_i, fits;

		if (j == 0) begin : g_first
			assign x_i = x_s1;
			assign y_i = y_s1;
			assign m_i = m_s1;
			assign z_i = zero_s1;
			assign v_i = v_s1;
		end else begin : g_next
			assign x_i = nx_s[j-1];
			assign y_i = ny_s[j-1];
			assign m_i = nm_s[j-1];
			assign z_i = nz_s[j-1];
			assign v_i = nv_s[j-1];
		end

		assign fits = (m_i >> (NT - SH)) == '0;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				nv_s[j] <= 1'b0;
			else if (en)
				nv_s[j] <= v_i;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				nx_s[j] <= fits ? x_i <<< SH : x_i;
				ny_s[j] <= fits ? y_i <<< SH : y_i;
				nm_s[j] <= fits ? m_i << SH : m_i;
				nz_s[j] <= z_i;
			end
		end
	end

	// fold the left half plane by a quarter turn
	logic signed [CW-1:0] fx_s2, fy_s2;
	logic signed [ZW-1:0] fz_s2;
	logic fzero_s2, fv_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			fv_s2 <= 1'b0;
		else if (en)
			fv_s2 <= nv_s[NS-1];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fzero_s2 <= nz_s[NS-1];
			if (!nx_s[NS-1][CW-1]) begin
				fx_s2 <= nx_s[NS-1];
				fy_s2 <= ny_s[NS-1];
				fz_s2 <= '0;
			end else if (!ny_s[NS-1][CW-1]) begin
				fx_s2 <= ny_s[NS-1];
				fy_s2 <= -nx_s[NS-1];
				fz_s2 <= QUARTER;
			end else begin
				fx_s2 <= -ny_s[NS-1];
				fy_s2 <= nx_s[NS-1];
				fz_s2 <= -QUARTER;
			end
		end
	end

	// cordic micro-rotations, one per stage
	logic signed [CW-1:0] cx_s [ITER];
	logic signed [CW-1:0] cy_s [ITER];
	logic signed [ZW-1:0] cz_s [ITER];
	logic czero_s [ITER];
	logic cv_s [ITER];

	for (genvar i = 0; i < ITER; i++) begin : g_rot
		localparam logic signed [ZW-1:0] ATN = ZW'(q2e_pkg::atan_turn(i));
		logic signed [CW-1:0] x_i, y_i, xs, ys;
		logic signed [ZW-1:0] z_i;
		logic zr_i, v_i;

		if (i == 0) begin : g_first
			assign x_i = fx_s2;
			assign y_i = fy_s2;
			assign z_i = fz_s2;
			assign zr_i = fzero_s2;
			assign v_i = fv_s2;
		end else begin : g_next
			assign x_i = cx_s[i-1];
			assign y_i = cy_s[i-1];
			assign z_i = cz_s[i-1];
			assign zr_i = czero_s[i-1];
			assign v_i = cv_s[i-1];
		end

		assign xs = x_i >>> i;
		assign ys = y_i >>> i;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				cv_s[i] <= 1'b0;
			else if (en)
				cv_s[i] <= v_i;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				czero_s[i] <= zr_i;
				if (!y_i[CW-1]) begin
					cx_s[i] <= x_i + ys;
					cy_s[i] <= y_i - xs;
					cz_s[i] <= z_i + ATN;
				end else begin
					cx_s[i] <= x_i - ys;
					cy_s[i] <= y_i + xs;
					cz_s[i] <= z_i - ATN;
				end
			end
		end
	end

	// both operands zero give angle zero
	assign valid_out = cv_s[ITER-1];
	assign angle = czero_s[ITER-1] ? '0 : cz_s[ITER-1];
endmodule
`default_nettype wire

/* design/q2e_scale.sv */
// angle to 0..180 scale in 1/128 steps with rounding and offset subtraction
`default_nettype none
module q2e_scale (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic en,
	input  wire logic valid_in,
	input  wire logic signed [q2e_pkg::ZW-1:0] roll_z,
	input  wire logic signed [q2e_pkg::ZW-1:0] pitch_z,
	input  wire logic signed [q2e_pkg::ZW-1:0] yaw_z,
	input  wire logic [q2e_pkg::OFS_W-1:0] roll_ofs,
	input  wire logic [q2e_pkg::OFS_W-1:0] pitch_ofs,
	input  wire logic [q2e_pkg::OFS_W-1:0] yaw_ofs,
	output logic valid_out,
	output q2e_pkg::euler_t res
);
	localparam int UW = q2e_pkg::UW;
	localparam int CLW = q2e_pkg::U_CLAMP_W;
	localparam int PRW = q2e_pkg::SPROD_W;
	localparam int OW = q2e_pkg::OUT_W;
	localparam logic signed [UW-1:0] HALF = UW'(64'sd1 <<< 31);
	localparam logic signed [UW-1:0] FULL = UW'(64'sd1 <<< 32);
	localparam logic [PRW-1:0] RND = PRW'(64'd1 << 31);
	localparam logic [PRW-1:0] SCALE = PRW'(q2e_pkg::SCALE_FULL);

	logic signed [q2e_pkg::ZW-1:0] z_in [3];
	logic [q2e_pkg::OFS_W-1:0] ofs [3];
	logic [CLW-1:0] u_s1 [3];
	logic [PRW-1:0] pr_s2 [3];
	logic signed [OW-1:0] o_s3 [3];
	logic v_s1, v_s2, v_s3;

	assign z_in[0] = roll_z;
	assign z_in[1] = pitch_z;
	assign z_in[2] = yaw_z;
	assign ofs[0] = roll_ofs;
	assign ofs[1] = pitch_ofs;
	assign ofs[2] = yaw_ofs;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= valid_in;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	for (genvar a = 0; a < 3; a++) begin : g_lane
		logic signed [UW-1:0] u_c;
		logic [PRW-1:0] sum_c;

		// pitch covers a half turn, so its angle is doubled
		always_comb begin
			if (a == 1)
				u_c = (UW'(z_in[a]) <<< 1) + HALF;
			else
				u_c = UW'(z_in[a]) + HALF;
			if (u_c < 0)
				u_c = '0;
			else if (u_c > FULL)
				u_c = FULL;
		end

		assign sum_c = pr_s2[a] + RND;

		always_ff @(posedge clk) begin
			if (en) begin
				u_s1[a]  <= u_c[CLW-1:0];
				pr_s2[a] <= PRW'(u_s1[a]) * SCALE;
				o_s3[a]  <= $signed(sum_c[PRW-1:32]) - $signed(OW'(ofs[a]));
			end
		end
	end

	assign valid_out = v_s3;
	assign res.roll = o_s3[0];
	assign res.pitch = o_s3[1];
	assign res.yaw = o_s3[2];
endmodule
`default_nettype wire

/* design/quaternion_to_scaled_euler.sv */
// top level: quaternion items in, scaled roll, pitch and yaw items out
//
// Quaternion items (w, x, y, z, signed Q1.15) enter on the quat channel and
// result items leave on the euler channel; both are valid/ready, an item moves
// at a clock edge with valid and ready high. The three offset registers are
// written through cfg_we, cfg_index and cfg_data (index 0 roll, 1 pitch,
// 2 yaw, other indexes ignored). The user must write them only while no item
// is in flight; the block itself does not enforce this. Throughput is one item
// per cycle while the skid register is empty. From accept to the result being
// shown, an item passes 4 product and operand stages, 30 square root stages
// (one root bit each), one magnitude, six normalization and one quadrant
// stage, one stage per cordic micro-rotation, and 3 scaling stages.
// Reset clears all valid bits and the offsets; the pipeline comes up empty.
// When the receiver stalls, the result at the end of the pipeline moves into
// a one-item skid register and the pipeline still takes one more item; with
// the skid register full the whole pipeline holds and quat.ready is low.
`default_nettype none
module quaternion_to_scaled_euler #(
	parameter int ANGLE_ITERATIONS = q2e_pkg::ANGLE_ITERATIONS_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	q2e_quat_if.sink quat,
	q2e_euler_if.source euler,
	input  wire logic cfg_we,
	input  wire logic [q2e_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [q2e_pkg::OFS_W-1:0] cfg_data
);
	localparam int OP_W = q2e_pkg::OP_W;

	logic [q2e_pkg::OFS_W-1:0] roll_ofs_q, pitch_ofs_q, yaw_ofs_q;
	logic en;
	logic front_v, sq_v, roll_v, pitch_v, yaw_v, last_v;
	q2e_pkg::front_data_t front_d, sq_d;
	logic [q2e_pkg::RAD_W-1:0] rad;
	logic [q2e_pkg::C_W-1:0] root;
	logic signed [q2e_pkg::ZW-1:0] roll_z, pitch_z, yaw_z;
	q2e_pkg::euler_t last_d, skid_q, shown;
	logic skid_v_q;

	// offset registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			roll_ofs_q <= '0;
			pitch_ofs_q <= '0;
			yaw_ofs_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				q2e_pkg::CFG_ROLL_OFFSET:  roll_ofs_q <= cfg_data;
				q2e_pkg::CFG_PITCH_OFFSET: pitch_ofs_q <= cfg_data;
				q2e_pkg::CFG_YAW_OFFSET:   yaw_ofs_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// the pipeline moves whenever the skid register is free
	assign en = !skid_v_q;
	assign quat.ready = en;

	q2e_front u_front (
		.clk, .arst_n, .en,
		.valid_in(quat.valid),
		.qw(quat.quat_w), .qx(quat.quat_x), .qy(quat.quat_y), .qz(quat.quat_z),
		.valid_out(front_v), .data_out(front_d), .rad_out(rad)
	);

	q2e_sqrt u_sqrt (
		.clk, .arst_n, .en,
		.valid_in(front_v), .data_in(front_d), .rad,
		.valid_out(sq_v), .data_out(sq_d), .root
	);

	q2e_atan #(.ITER(ANGLE_ITERATIONS)) u_roll (
		.clk, .arst_n, .en, .valid_in(sq_v),
		.y_in(sq_d.rn), .x_in(sq_d.rd),
		.valid_out(roll_v), .angle(roll_z)
	);

	q2e_atan #(.ITER(ANGLE_ITERATIONS)) u_pitch (
		.clk, .arst_n, .en, .valid_in(sq_v),
		.y_in(OP_W'(sq_d.p)), .x_in(OP_W'($signed({1'b0, root}))),
		.valid_out(pitch_v), .angle(pitch_z)
	);

	q2e_atan #(.ITER(ANGLE_ITERATIONS)) u_yaw (
		.clk, .arst_n, .en, .valid_in(sq_v),
		.y_in(sq_d.yn), .x_in(sq_d.yd),
		.valid_out(yaw_v), .angle(yaw_z)
	);

	q2e_scale u_scale (
		.clk, .arst_n, .en, .valid_in(roll_v),
		.roll_z, .pitch_z, .yaw_z,
		.roll_ofs(roll_ofs_q), .pitch_ofs(pitch_ofs_q), .yaw_ofs(yaw_ofs_q),
		.valid_out(last_v), .res(last_d)
	);

	// skid register behind the last stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			skid_v_q <= 1'b0;
		else if (skid_v_q)
			skid_v_q <= !euler.ready;
		else
			skid_v_q <= last_v && !euler.ready;
	end

	always_ff @(posedge clk) begin
		if (!skid_v_q)
			skid_q <= last_d;
	end

	assign shown = skid_v_q ? skid_q : last_d;
	assign euler.valid = skid_v_q || last_v;
	assign euler.roll_scaled = shown.roll;
	assign euler.pitch_scaled = shown.pitch;
	assign euler.yaw_scaled = shown.yaw;

	// the skid register only fills from a stalled valid result
	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_v_q) |-> $past(last_v && !euler.ready))
		else $error("skid register filled without a stalled result");

	// the three angle pipelines run in lockstep
	a_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		(roll_v == pitch_v) && (pitch_v == yaw_v))
		else $error("angle pipelines out of step");

	// a held skid item stays unchanged until taken
	a_skid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q && !euler.ready |=> skid_v_q && $stable(skid_q))
		else $error("skid item changed while stalled");
endmodule
`default_nettype wire
